// File: rtl/r2a_pkg.sv
`default_nettype none

package r2a_pkg;

  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 7;
  localparam int TOTAL_W = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] DEC_DIGITS  = 6'd10;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_A    = 7'h41;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic store;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic quot_zero;
    logic last;
    logic out_free;
  } sts_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DEC_DIGITS) begin
      res = ASCII_ZERO + {1'b0, d};
    end else begin
      res = ASCII_A + {1'b0, d - DEC_DIGITS};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/r2a_ram.sv
`default_nettype none

module r2a_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one entry, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/r2a_ctrl.sv
`default_nettype none

module r2a_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire r2a_pkg::sts_t sts,
  output r2a_pkg::cmd_t      cmd
);
  import r2a_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_STORE = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Sequence: divide bit by bit, store digit, then read digits back in reverse
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        state_nxt = sts.quot_zero ? S_RD : S_DIV;
      end
      S_RD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = sts.last ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/r2a_dp.sv
`default_nettype none

module r2a_dp #(
  parameter int VALUE_BITS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [63:0]                     in_number_in,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [r2a_pkg::RADIX_W-1:0]     cfg_radix,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [r2a_pkg::CHAR_W-1:0]      out_digit_char,
  output logic                                 out_last_digit,
  output logic      [r2a_pkg::TOTAL_W-1:0]     out_digit_total,
  input  wire r2a_pkg::cmd_t                   cmd,
  output r2a_pkg::sts_t                        sts
);
  import r2a_pkg::*;

  localparam int AW = $clog2(VALUE_BITS);
  localparam int CW = $clog2(VALUE_BITS + 1);
  localparam int BW = $clog2(VALUE_BITS);
  localparam logic [BW-1:0] BIT_LAST = BW'(VALUE_BITS - 1);

  logic [RADIX_W-1:0]    radix_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [RADIX_W-1:0]    rem_r;
  logic [BW-1:0]         bit_r;
  logic [CW-1:0]         cnt_r;
  logic [AW-1:0]         rd_ptr_r;
  logic                  out_valid_r;
  logic [CHAR_W-1:0]     char_r;
  logic                  last_r;
  logic [TOTAL_W-1:0]    total_r;

  logic [RADIX_W:0]      trial;
  logic                  ge;
  logic [RADIX_W:0]      diff;
  logic [RADIX_W-1:0]    rd_digit;

  // Restoring division step: shift in one dividend bit, subtract radix if it fits
  assign trial = {rem_r, val_r[VALUE_BITS-1]};
  assign ge    = trial >= {1'b0, radix_r};
  assign diff  = trial - {1'b0, radix_r};

  assign cfg_ready = 1'b1;

  // Radix register, saturated on write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_valid) begin
      radix_r <= clamp_radix(cfg_radix);
    end
  end

  // Dividend, remainder and digit count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r <= in_number_in[VALUE_BITS-1:0];
      rem_r <= '0;
      bit_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      val_r <= {val_r[VALUE_BITS-2:0], ge};
      rem_r <= ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
      bit_r <= bit_r + 1'b1;
    end else if (cmd.store) begin
      rem_r <= '0;
      bit_r <= '0;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Read pointer walks from the most significant digit down
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      rd_ptr_r <= cnt_r[AW-1:0];
    end else if (cmd.out_load) begin
      rd_ptr_r <= rd_ptr_r - 1'b1;
    end
  end

  r2a_ram #(
    .WIDTH(RADIX_W),
    .DEPTH(VALUE_BITS)
  ) u_digits (
    .clk  (clk),
    .we   (cmd.store),
    .waddr(cnt_r[AW-1:0]),
    .wdata(rem_r),
    .raddr(rd_ptr_r),
    .rdata(rd_digit)
  );

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      char_r  <= digit_to_ascii(rd_digit);
      last_r  <= (rd_ptr_r == '0);
      total_r <= TOTAL_W'(cnt_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_digit_char  = char_r;
  assign out_last_digit  = last_r;
  assign out_digit_total = total_r;

  assign sts.div_done  = (bit_r == BIT_LAST);
  assign sts.quot_zero = (val_r == '0);
  assign sts.last      = (rd_ptr_r == '0);
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

`default_nettype wire

// File: rtl/radix_to_ascii_converter.sv
`default_nettype none

// Chan | Handshake            | Payload                                         | Item
// in   | in_valid, in_ready   | in_number_in                                    | value to convert
// out  | out_valid, out_ready | out_digit_char, out_last_digit, out_digit_total | digit, MSD first
// cfg  | cfg_valid, cfg_ready | cfg_radix                                       | radix, 2..36
//
// The bit-serial divider produces each digit (one quotient bit a cycle), and the digits are
// then read back from the digit RAM. Reset sets the radix to 10 and empties the output
// register. A stalled output holds the digit read-back; the next item is taken while the
// final digit still waits.

module radix_to_ascii_converter #(
  parameter int VALUE_BITS = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [63:0]                 in_number_in,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [r2a_pkg::CHAR_W-1:0]  out_digit_char,
  output logic                             out_last_digit,
  output logic      [r2a_pkg::TOTAL_W-1:0] out_digit_total,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [r2a_pkg::RADIX_W-1:0] cfg_radix
);
  import r2a_pkg::*;

  cmd_t cmd;
  sts_t sts;

  r2a_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  r2a_dp #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_number_in   (in_number_in),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_radix      (cfg_radix),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit),
    .out_digit_total(out_digit_total),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

`default_nettype wire

// File: tb/radix_to_ascii_converter_test.sv
`timescale 1ns / 1ps

module radix_to_ascii_converter_test;
  import r2a_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int HOLD_CYCLES    = 3000;
  localparam int RANDOM_PHASES  = 7;
  localparam int PHASE_ITEMS    = 17;
  localparam int REPORT_LIMIT   = 10;
  localparam logic [63:0] ALL_ONES = '1;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic               last;
    logic [TOTAL_W-1:0] total;
  } digit_t;

  // Predict the digit string of each accepted value and check the digits as they arrive
  class digit_checker;
    logic [RADIX_W-1:0] base;
    digit_t             pending_digits[$];
    int                 digit_errors;

    function new();
      base         = RADIX_RESET;
      digit_errors = 0;
    endfunction

    // Saturate a written radix into 2..36
    function void set_radix(logic [RADIX_W-1:0] raw);
      if (raw < RADIX_MIN) begin
        base = RADIX_MIN;
      end else if (raw > RADIX_MAX) begin
        base = RADIX_MAX;
      end else begin
        base = raw;
      end
    endfunction

    function void note_value(logic [63:0] value);
      logic [63:0]        rest;
      logic [63:0]        rem;
      logic [RADIX_W-1:0] rev[$];
      logic [RADIX_W-1:0] d;
      digit_t             item;
      int                 k;
      rest = value;
      // Peel off digits least significant first
      do begin
        rem  = rest % base;
        rev.push_back(rem[RADIX_W-1:0]);
        rest = rest / base;
      end while (rest != 0);
      // Queue them most significant first
      for (k = rev.size() - 1; k >= 0; k--) begin
        d = rev[k];
        if (d < 6'd10) begin
          item.ch = ASCII_ZERO + CHAR_W'(d);
        end else begin
          item.ch = ASCII_A + CHAR_W'(d - 6'd10);
        end
        item.last  = (k == 0);
        item.total = TOTAL_W'(rev.size());
        pending_digits.push_back(item);
      end
    endfunction

    function void check_digit(digit_t got);
      digit_t want;
      if (pending_digits.size() == 0) begin
        digit_errors++;
        if (digit_errors <= REPORT_LIMIT) begin
          $display("unexpected digit: char %h last %b total %0d",
                   got.ch, got.last, got.total);
        end
      end else begin
        want = pending_digits.pop_front();
        if (got !== want) begin
          digit_errors++;
          if (digit_errors <= REPORT_LIMIT) begin
            $display("digit mismatch: expected char %h last %b total %0d",
                     want.ch, want.last, want.total);
            $display("                got      char %h last %b total %0d",
                     got.ch, got.last, got.total);
          end
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [63:0]         in_number_in;
  logic                out_valid;
  logic                out_ready;
  logic [CHAR_W-1:0]   out_digit_char;
  logic                out_last_digit;
  logic [TOTAL_W-1:0]  out_digit_total;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [RADIX_W-1:0]  cfg_radix;

  digit_checker ledger;
  int           idle_pct     = 19;
  bit           hold_request = 1'b0;
  int           quiet_cycles = 0;

  radix_to_ascii_converter #(
    .VALUE_BITS(64)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_number_in    (in_number_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digit_char  (out_digit_char),
    .out_last_digit  (out_last_digit),
    .out_digit_total (out_digit_total),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_radix       (cfg_radix)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Offer one value, idling at random first; valid stays high after acceptance
  task automatic send_value(input logic [63:0] value);
    while ($urandom_range(99, 0) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_number_in <= value;
    do @(posedge clk); while (in_ready !== 1'b1);
    ledger.note_value(value);
  endtask

  // Drop valid and wait for every outstanding digit
  task automatic drain();
    in_valid <= 1'b0;
    while (ledger.pending_digits.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] raw);
    cfg_valid <= 1'b1;
    cfg_radix <= raw;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    ledger.set_radix(raw);
  endtask

  // Mostly short values, some full width, some on digit-count boundaries
  function automatic logic [63:0] pick_value(input logic [RADIX_W-1:0] base);
    logic [63:0] power;
    int          steps;
    int          roll;
    int          i;
    roll = $urandom_range(99, 0);
    if (roll < 45) return 64'($urandom_range(5000, 0));
    if (roll < 65) return {32'd0, $urandom};
    if (roll < 85) return {$urandom, $urandom};
    roll = $urandom_range(3, 0);
    if (roll == 0) return '0;
    if (roll == 1) return ALL_ONES;
    power = 64'd1;
    steps = $urandom_range(63, 1);
    for (i = 0; i < steps && power <= ALL_ONES / base; i++) begin
      power = power * base;
    end
    return (roll == 2) ? power : power - 64'd1;
  endfunction

  // Receive digits; honor a long hold-off when one is requested
  initial begin
    int     hold_left;
    digit_t got;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        got.ch    = out_digit_char;
        got.last  = out_last_digit;
        got.total = out_digit_total;
        ledger.check_digit(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99, 0) >= idle_pct);
      end
    end
  end

  // Abort when no channel has moved an item for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [RADIX_W-1:0] phase_radix[RANDOM_PHASES];
    int                 p;
    int                 n;
    phase_radix  = '{6'd2, 6'd16, 6'd36, 6'd0, 6'd8, 6'd0, 6'd3};
    ledger       = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_number_in = '0;
    cfg_valid    = 1'b0;
    cfg_radix    = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset radix: zero, one digit, carry into two digits, full width
    send_value(64'd0);
    send_value(64'd9);
    send_value(64'd10);
    send_value(ALL_ONES);
    send_value(64'h8000_0000_0000_0000);
    drain();

    // Radix below range acts as 2: longest digit strings
    write_radix(6'd0);
    send_value(64'd1);
    send_value(ALL_ONES);
    send_value(64'h5555_5555_5555_5555);
    send_value(64'd0);
    drain();

    // Radix above range acts as 36: letters up to Z
    write_radix(6'd63);
    send_value(64'd35);
    send_value(64'd36);
    send_value(64'd1295);
    send_value(ALL_ONES);
    drain();

    write_radix(6'd37);
    send_value(64'hAAAA_AAAA_AAAA_AAAA);
    send_value(64'd46655);
    drain();

    write_radix(6'd1);
    send_value(64'd2);
    send_value(64'hFFFF_FFFF);
    drain();

    write_radix(6'd36);
    send_value(64'd1296);
    drain();

    // Random phases, each under its own radix
    for (p = 0; p < RANDOM_PHASES; p++) begin
      if (phase_radix[p] == 6'd0) begin
        write_radix(RADIX_W'($urandom_range(63, 0)));
      end else begin
        write_radix(phase_radix[p]);
      end
      idle_pct = (p == 4) ? 0 : 19;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == 3) begin
          hold_request = 1'b1;
        end
        send_value(pick_value(ledger.base));
      end
      drain();
    end

    // Let any stray digit show up before the verdict
    repeat (100) @(posedge clk);
    if (ledger.digit_errors == 0 && ledger.pending_digits.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
